// ----- design/vefe_pkg.sv -----
package vefe_pkg;

	// Default sizes of the occupancy grid and the colour palette.
	localparam int unsigned GRID_SIDE_DEF     = 32;
	localparam int unsigned PALETTE_DEPTH_DEF = 256;

	// Command modes.
	localparam logic [1:0] MODE_OCC   = 2'd0;
	localparam logic [1:0] MODE_PAL   = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;

	// Face codes in the order the neighbors are tested.
	localparam logic [2:0] FACE_YP   = 3'd0;
	localparam logic [2:0] FACE_YN   = 3'd1;
	localparam logic [2:0] FACE_ZP   = 3'd2;
	localparam logic [2:0] FACE_ZN   = 3'd3;
	localparam logic [2:0] FACE_XP   = 3'd4;
	localparam logic [2:0] FACE_XN   = 3'd5;
	localparam logic [2:0] FACE_NONE = 3'd6;

	// Number of neighbors tested per query.
	localparam int unsigned FACE_COUNT = 6;

	// Access request to the occupancy memory.
	typedef struct packed {
		logic en;
		logic we;
		logic wbit;
	} occ_req_t;

	// Access request to the palette memory.
	typedef struct packed {
		logic        we;
		logic        re;
		logic [7:0]  slot;
		logic [23:0] wdata;
	} pal_req_t;

endpackage

// ----- design/vefe_cmd_if.sv -----
interface vefe_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [4:0]  pos_x;
	logic [4:0]  pos_y;
	logic [4:0]  pos_z;
	logic        occupied;
	logic [7:0]  color_index;
	logic [7:0]  palette_slot;
	logic [23:0] palette_rgb;

	modport source (
		output valid, mode, pos_x, pos_y, pos_z, occupied, color_index,
			palette_slot, palette_rgb,
		input  ready
	);

	modport sink (
		input  valid, mode, pos_x, pos_y, pos_z, occupied, color_index,
			palette_slot, palette_rgb,
		output ready
	);
endinterface

// ----- design/vefe_face_if.sv -----
interface vefe_face_if;
	logic       valid;
	logic       ready;
	logic [2:0] face_code;
	logic [4:0] vertex_base;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [4:0] place_x;
	logic [4:0] place_y;
	logic [4:0] place_z;
	logic       last;

	modport source (
		output valid, face_code, vertex_base, red, green, blue,
			place_x, place_y, place_z, last,
		input  ready
	);

	modport sink (
		input  valid, face_code, vertex_base, red, green, blue,
			place_x, place_y, place_z, last,
		output ready
	);
endinterface

// ----- design/vefe_occ_grid.sv -----
module vefe_occ_grid #(
	parameter int unsigned GRID_SIDE = vefe_pkg::GRID_SIDE_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  vefe_pkg::occ_req_t                   req,
	input  logic [$clog2(GRID_SIDE**3)-1:0]      addr,
	output logic                                 rdata,
	output logic                                 busy
);
	import vefe_pkg::*;

	localparam int unsigned DEPTH = GRID_SIDE**3;
	localparam int unsigned AW    = $clog2(DEPTH);

	logic          grid_mem_q [DEPTH];
	logic          rdata_q;
	logic [AW-1:0] clr_cnt_q;
	logic          busy_q;

	// Clearing sweep after reset: one cell per cycle until the last address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			busy_q    <= 1'b1;
		end else if (busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Single port: the sweep, a write or a registered read.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			grid_mem_q[clr_cnt_q] <= 1'b0;
		end else if (req.en && req.we) begin
			grid_mem_q[addr] <= req.wbit;
		end else if (req.en) begin
			rdata_q <= grid_mem_q[addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

// ----- design/vefe_palette.sv -----
module vefe_palette #(
	parameter int unsigned PALETTE_DEPTH = vefe_pkg::PALETTE_DEPTH_DEF
) (
	input  logic               clk,
	input  vefe_pkg::pal_req_t req,
	output logic [23:0]        rdata
);
	import vefe_pkg::*;

	localparam int unsigned PW = $clog2(PALETTE_DEPTH);

	logic [23:0] pal_mem_q [PALETTE_DEPTH];
	logic [23:0] rd_data_q;
	logic        rd_ok_q;
	logic        slot_ok;

	// Slots at or beyond the depth are not stored and read as black.
	assign slot_ok = ({1'b0, req.slot} < 9'(PALETTE_DEPTH));

	always_ff @(posedge clk) begin
		if (req.we && slot_ok) begin
			pal_mem_q[req.slot[PW-1:0]] <= req.wdata;
		end
		if (req.re) begin
			rd_ok_q <= slot_ok;
			if (slot_ok) begin
				rd_data_q <= pal_mem_q[req.slot[PW-1:0]];
			end
		end
	end

	assign rdata = rd_ok_q ? rd_data_q : 24'd0;

endmodule

// ----- design/vefe_seq.sv -----
module vefe_seq #(
	parameter int unsigned GRID_SIDE = vefe_pkg::GRID_SIDE_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	vefe_cmd_if.sink                          cmd,
	vefe_face_if.source                       face,
	output vefe_pkg::occ_req_t                occ_req,
	output logic [$clog2(GRID_SIDE**3)-1:0]   occ_addr,
	input  logic                              occ_rdata,
	input  logic                              grid_busy,
	output vefe_pkg::pal_req_t                pal_req,
	input  logic [23:0]                       pal_rdata
);
	import vefe_pkg::*;

	localparam int unsigned AW      = $clog2(GRID_SIDE**3);
	localparam int unsigned SIDE_SQ = GRID_SIDE * GRID_SIDE;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [4:0] px_q, py_q, pz_q;
	logic [2:0] face_q;
	logic [5:0] mask_q;
	logic [2:0] cnt_q;

	logic       valid_s1;
	logic [2:0] face_s1;
	logic       in_s1;

	logic       out_valid_q;
	logic [2:0] face_code_q;
	logic [4:0] vertex_base_q;
	logic [23:0] rgb_q;
	logic [4:0] place_x_q;
	logic [4:0] place_y_q;
	logic [4:0] place_z_q;
	logic       last_q;

	logic       acc;
	logic       cmd_in_grid;
	logic [5:0] nx, ny, nz;
	logic       under;
	logic       n_in;
	logic [2:0] pick;
	logic       found;
	logic [5:0] rest;
	logic [2:0] rec_face;
	logic       rec_last;
	logic       load;

	// Linear cell address, z major, then y, then x.
	function automatic logic [AW-1:0] lin_addr(input logic [5:0] x, input logic [5:0] y,
			input logic [5:0] z);
		logic [31:0] s;
		s = 32'(z) * 32'(SIDE_SQ) + 32'(y) * 32'(GRID_SIDE) + 32'(x);
		return s[AW-1:0];
	endfunction

	assign cmd.ready = (state_q == ST_IDLE) && !grid_busy;
	assign acc       = cmd.valid && cmd.ready;

	assign cmd_in_grid = ({4'b0000, cmd.pos_x} < 9'(GRID_SIDE)) &&
		({4'b0000, cmd.pos_y} < 9'(GRID_SIDE)) &&
		({4'b0000, cmd.pos_z} < 9'(GRID_SIDE));

	// Neighbor coordinates for the face being read; off-grid neighbors skip the read.
	always_comb begin
		nx    = {1'b0, px_q};
		ny    = {1'b0, py_q};
		nz    = {1'b0, pz_q};
		under = 1'b0;
		case (face_q)
			FACE_YP: ny = ny + 6'd1;
			FACE_YN: begin
				under = (py_q == 5'd0);
				ny    = ny - 6'd1;
			end
			FACE_ZP: nz = nz + 6'd1;
			FACE_ZN: begin
				under = (pz_q == 5'd0);
				nz    = nz - 6'd1;
			end
			FACE_XP: nx = nx + 6'd1;
			FACE_XN: begin
				under = (px_q == 5'd0);
				nx    = nx - 6'd1;
			end
			default: ;
		endcase
		n_in = !under && ({3'b000, nx} < 9'(GRID_SIDE)) &&
			({3'b000, ny} < 9'(GRID_SIDE)) && ({3'b000, nz} < 9'(GRID_SIDE));
	end

	// Occupancy port: command writes while idle, neighbor reads during a query.
	always_comb begin
		if (state_q == ST_IDLE) begin
			occ_req.en   = acc && (cmd.mode == MODE_OCC) && cmd_in_grid;
			occ_req.we   = 1'b1;
			occ_addr     = lin_addr({1'b0, cmd.pos_x}, {1'b0, cmd.pos_y}, {1'b0, cmd.pos_z});
		end else begin
			occ_req.en   = (state_q == ST_READ) && n_in;
			occ_req.we   = 1'b0;
			occ_addr     = lin_addr(nx, ny, nz);
		end
		occ_req.wbit = cmd.occupied;
	end

	// Palette port: a write for palette commands, a read of the one-based index for queries.
	always_comb begin
		pal_req.we    = acc && (cmd.mode == MODE_PAL);
		pal_req.re    = acc && (cmd.mode == MODE_QUERY);
		pal_req.slot  = (cmd.mode == MODE_PAL) ? cmd.palette_slot : cmd.color_index - 8'd1;
		pal_req.wdata = cmd.palette_rgb;
	end

	// Next exposed face still to be sent, lowest face code first.
	always_comb begin
		pick  = 3'd0;
		found = 1'b0;
		for (int i = 0; i < FACE_COUNT; i++) begin
			if (!found && mask_q[i]) begin
				pick  = 3'(i);
				found = 1'b1;
			end
		end
		rest     = found ? (mask_q & ~(6'd1 << pick)) : 6'd0;
		rec_face = found ? pick : FACE_NONE;
		rec_last = (rest == 6'd0);
	end

	assign load = (state_q == ST_EMIT) && (!out_valid_q || face.ready);

	// Query sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			face_q   <= 3'd0;
			cnt_q    <= 3'd0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_READ);
			case (state_q)
				ST_IDLE: begin
					if (acc && (cmd.mode == MODE_QUERY)) begin
						state_q <= ST_READ;
						face_q  <= 3'd0;
						cnt_q   <= 3'd0;
					end
				end
				ST_READ: begin
					face_q <= face_q + 3'd1;
					if (face_q == FACE_XN) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (load) begin
						cnt_q <= cnt_q + 3'd1;
						if (rec_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Query coordinates, read pipeline and exposed-face mask.
	always_ff @(posedge clk) begin
		if (acc) begin
			px_q <= cmd.pos_x;
			py_q <= cmd.pos_y;
			pz_q <= cmd.pos_z;
		end
		face_s1 <= face_q;
		in_s1   <= n_in;
		if (valid_s1) begin
			mask_q[face_s1] <= !(in_s1 && occ_rdata);
		end else if (load) begin
			mask_q <= rest;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (face.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The record keeps its own copy of the position, since a new command may be
	// taken while the final record still waits on the face side.
	always_ff @(posedge clk) begin
		if (load) begin
			face_code_q   <= rec_face;
			vertex_base_q <= {cnt_q, 2'b00};
			rgb_q         <= pal_rdata;
			place_x_q     <= px_q;
			place_y_q     <= pz_q;
			place_z_q     <= py_q;
			last_q        <= rec_last;
		end
	end

	assign face.valid       = out_valid_q;
	assign face.face_code   = face_code_q;
	assign face.vertex_base = vertex_base_q;
	assign face.red         = rgb_q[7:0];
	assign face.green       = rgb_q[15:8];
	assign face.blue        = rgb_q[23:16];
	assign face.place_x     = place_x_q;
	assign face.place_y     = place_y_q;
	assign face.place_z     = place_z_q;
	assign face.last        = last_q;

`ifndef SYNTHESIS
	// A query starts its neighbor reads at the lowest face.
	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (cmd.mode == MODE_QUERY)) |=> (state_q == ST_READ && face_q == 3'd0))
		else $error("query did not start reading at the first face");

	// The final record of a query returns the sequencer to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && rec_last) |=> (state_q == ST_IDLE))
		else $error("sequencer not idle after the final record");

	// No occupancy access competes with the clearing sweep.
	a_no_access_clear: assert property (@(posedge clk) disable iff (!arst_n)
		grid_busy |-> !occ_req.en)
		else $error("occupancy access during clearing sweep");

	// Read results arrive only while the neighbor reads are in flight.
	a_s1_window: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ST_READ || state_q == ST_WAIT))
		else $error("read result outside the read window");

	// A query never sends more records than it has faces.
	a_record_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (cnt_q < 3'd6))
		else $error("too many records for one query");
`endif

endmodule

// ----- design/voxel_exposed_face_emitter.sv -----
// Voxel exposed-face emitter. Commands on cmd set or clear one occupancy cell, write one
// palette word, or query a voxel. A query reads the six neighbors (y+, y-, z+, z-, x+,
// x-) one after another from the single-port occupancy memory, then sends one record on
// face per empty or off-grid neighbor, or one record with face code 6 when none is
// exposed (1 to 6 records); cmd is held off until the last record is loaded into the
// output register. After reset a clearing pass sweeps all GRID_SIDE**3 cells of the
// occupancy memory (32768 at the default size), one cell per cycle, during which no
// command is taken.
module voxel_exposed_face_emitter #(
	parameter int unsigned GRID_SIDE     = vefe_pkg::GRID_SIDE_DEF,
	parameter int unsigned PALETTE_DEPTH = vefe_pkg::PALETTE_DEPTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	vefe_cmd_if.sink    cmd,
	vefe_face_if.source face
);
	import vefe_pkg::*;

	localparam int unsigned AW = $clog2(GRID_SIDE**3);

	occ_req_t      occ_req;
	logic [AW-1:0] occ_addr;
	logic          occ_rdata;
	logic          grid_busy;
	pal_req_t      pal_req;
	logic [23:0]   pal_rdata;

	// Occupancy memory with its clearing sweep.
	vefe_occ_grid #(
		.GRID_SIDE(GRID_SIDE)
	) u_grid (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (occ_req),
		.addr  (occ_addr),
		.rdata (occ_rdata),
		.busy  (grid_busy)
	);

	// Colour palette.
	vefe_palette #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk  (clk),
		.req  (pal_req),
		.rdata(pal_rdata)
	);

	// Command decode, neighbor reads and record output.
	vefe_seq #(
		.GRID_SIDE(GRID_SIDE)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.face     (face),
		.occ_req  (occ_req),
		.occ_addr (occ_addr),
		.occ_rdata(occ_rdata),
		.grid_busy(grid_busy),
		.pal_req  (pal_req),
		.pal_rdata(pal_rdata)
	);

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import vefe_pkg::*;

	// Command code that the block must ignore.
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int GRID = 32;
	localparam int CELLS = GRID * GRID * GRID;
	localparam int PAL_WORDS = 256;
	localparam int HOLD_CYCLES = 200;
	localparam int RANDOM_ITEMS = 135;
	localparam int PRESSURE_ITEMS = 24;

	typedef struct {
		logic [1:0]  mode;
		logic [4:0]  x;
		logic [4:0]  y;
		logic [4:0]  z;
		logic        occ;
		logic [7:0]  cidx;
		logic [7:0]  slot;
		logic [23:0] rgb;
	} voxel_cmd_t;

	typedef struct {
		logic [2:0] face;
		logic [4:0] vbase;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [4:0] px;
		logic [4:0] py;
		logic [4:0] pz;
		logic       is_last;
	} face_rec_t;

	logic clk;
	logic arst_n;

	vefe_cmd_if cmd_bus();
	vefe_face_if face_bus();

	voxel_exposed_face_emitter uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_bus),
		.face(face_bus)
	);

	// Predictor state: occupancy bits and palette words.
	bit          solid_cells [0:CELLS-1];
	logic [23:0] palette_words [0:PAL_WORDS-1];
	bit          palette_written [0:PAL_WORDS-1];
	logic [7:0]  written_slots [$];
	face_rec_t   pending_faces [$];

	int error_count = 0;
	int n_occ_writes = 0;
	int n_pal_writes = 0;
	int n_queries = 0;
	int n_records = 0;

	// Sender burst control and receiver hold request.
	bit gaps_on = 1'b1;
	int burst_left = 0;
	bit hold_request = 1'b0;

	// Cluster origin for the random traffic.
	logic [4:0] base_x, base_y, base_z;

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog covering the clearing pass after reset and the slowest legal run.
	initial begin
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic bit cell_solid(input int x, input int y, input int z);
		if (x < 0 || y < 0 || z < 0 || x >= GRID || y >= GRID || z >= GRID) begin
			return 1'b0;
		end
		return solid_cells[(z * GRID + y) * GRID + x];
	endfunction

	// Computes the face records that one accepted command produces.
	function automatic void model_voxel_cmd(input voxel_cmd_t c);
		int step_x [6] = '{0, 0, 0, 0, 1, -1};
		int step_y [6] = '{1, -1, 0, 0, 0, 0};
		int step_z [6] = '{0, 0, 1, -1, 0, 0};
		logic [2:0] face_of [6] = '{FACE_YP, FACE_YN, FACE_ZP, FACE_ZN, FACE_XP, FACE_XN};
		logic [2:0] open_faces [$];
		logic [23:0] colour;
		logic [7:0] pal_slot;
		face_rec_t rec;
		int f;

		case (c.mode)
			MODE_OCC: begin
				solid_cells[(int'(c.z) * GRID + int'(c.y)) * GRID + int'(c.x)] = c.occ;
				n_occ_writes++;
			end
			MODE_PAL: begin
				palette_words[c.slot] = c.rgb;
				if (!palette_written[c.slot]) begin
					palette_written[c.slot] = 1'b1;
					written_slots.insert(written_slots.size(), c.slot);
				end
				n_pal_writes++;
			end
			MODE_QUERY: begin
				pal_slot = c.cidx - 8'd1;
				colour = palette_words[pal_slot];
				for (f = 0; f < 6; f++) begin
					if (!cell_solid(int'(c.x) + step_x[f], int'(c.y) + step_y[f],
							int'(c.z) + step_z[f])) begin
						open_faces.insert(open_faces.size(), face_of[f]);
					end
				end
				if (open_faces.size() == 0) begin
					open_faces.insert(0, FACE_NONE);
				end
				for (f = 0; f < open_faces.size(); f++) begin
					rec.face = open_faces[f];
					rec.vbase = 5'(4 * f);
					rec.red = colour[7:0];
					rec.green = colour[15:8];
					rec.blue = colour[23:16];
					rec.px = c.x;
					rec.py = c.z;
					rec.pz = c.y;
					rec.is_last = (f == open_faces.size() - 1);
					pending_faces.insert(pending_faces.size(), rec);
				end
				n_queries++;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic voxel_cmd_t make_cmd(input logic [1:0] mode, input logic [4:0] x,
			input logic [4:0] y, input logic [4:0] z, input logic occ,
			input logic [7:0] cidx, input logic [7:0] slot, input logic [23:0] rgb);
		voxel_cmd_t c;
		c.mode = mode;
		c.x = x;
		c.y = y;
		c.z = z;
		c.occ = occ;
		c.cidx = cidx;
		c.slot = slot;
		c.rgb = rgb;
		return c;
	endfunction

	// Offers one command and waits for the edge that accepts it; a burst gap may follow.
	task automatic send_cmd(input voxel_cmd_t c);
		int gap;
		@(negedge clk);
		cmd_bus.valid <= 1'b1;
		cmd_bus.mode <= c.mode;
		cmd_bus.pos_x <= c.x;
		cmd_bus.pos_y <= c.y;
		cmd_bus.pos_z <= c.z;
		cmd_bus.occupied <= c.occ;
		cmd_bus.color_index <= c.cidx;
		cmd_bus.palette_slot <= c.slot;
		cmd_bus.palette_rgb <= c.rgb;
		@(posedge clk);
		while (!cmd_bus.ready) begin
			@(posedge clk);
		end
		model_voxel_cmd(c);
		// Close the burst with an idle gap once it runs out.
		if (gaps_on) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				gap = $urandom_range(1, 6);
				burst_left = $urandom_range(0, 12);
				@(negedge clk);
				cmd_bus.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	// A color index whose palette entry has been written.
	function automatic logic [7:0] known_color_index();
		logic [7:0] slot;
		slot = written_slots[$urandom_range(0, written_slots.size() - 1)];
		return slot + 8'd1;
	endfunction

	function automatic logic [4:0] near_base(input logic [4:0] b);
		return b + 5'($urandom_range(0, 2));
	endfunction

	function automatic void move_cluster();
		if ($urandom_range(0, 3) == 0) begin
			base_x = $urandom_range(0, 1) ? 5'd29 : 5'd0;
			base_y = $urandom_range(0, 1) ? 5'd29 : 5'd0;
			base_z = $urandom_range(0, 1) ? 5'd29 : 5'd0;
		end else begin
			base_x = 5'($urandom_range(0, 29));
			base_y = 5'($urandom_range(0, 29));
			base_z = 5'($urandom_range(0, 29));
		end
	endfunction

	// Field extremes, every command, the grid corners, an enclosed voxel and index wrap.
	task automatic test_directed_cases();
		send_cmd(make_cmd(MODE_PAL, 5'd0, 5'd0, 5'd0, 1'b0, 8'd0, 8'd0, 24'hFFFFFF));
		send_cmd(make_cmd(MODE_PAL, 5'd0, 5'd0, 5'd0, 1'b0, 8'd0, 8'd255, 24'h000000));
		send_cmd(make_cmd(MODE_PAL, 5'd0, 5'd0, 5'd0, 1'b0, 8'd0, 8'd254, 24'hA5C3E1));
		send_cmd(make_cmd(MODE_PAL, 5'd0, 5'd0, 5'd0, 1'b0, 8'd0, 8'd127, 24'h5A3C1E));
		send_cmd(make_cmd(MODE_UNUSED, 5'd31, 5'd31, 5'd31, 1'b1, 8'd255, 8'd255,
			24'hFFFFFF));
		// Corner voxels see off-grid neighbors on three sides.
		send_cmd(make_cmd(MODE_QUERY, 5'd0, 5'd0, 5'd0, 1'b0, 8'd1, 8'd0, 24'h0));
		send_cmd(make_cmd(MODE_QUERY, 5'd31, 5'd31, 5'd31, 1'b1, 8'd0, 8'd255, 24'h0));
		// Wall in one voxel on all six sides.
		send_cmd(make_cmd(MODE_OCC, 5'd10, 5'd11, 5'd10, 1'b1, 8'd0, 8'd0, 24'h0));
		send_cmd(make_cmd(MODE_OCC, 5'd10, 5'd9, 5'd10, 1'b1, 8'd0, 8'd0, 24'h0));
		send_cmd(make_cmd(MODE_OCC, 5'd10, 5'd10, 5'd11, 1'b1, 8'd0, 8'd0, 24'h0));
		send_cmd(make_cmd(MODE_OCC, 5'd10, 5'd10, 5'd9, 1'b1, 8'd0, 8'd0, 24'h0));
		send_cmd(make_cmd(MODE_OCC, 5'd11, 5'd10, 5'd10, 1'b1, 8'd0, 8'd0, 24'h0));
		send_cmd(make_cmd(MODE_OCC, 5'd9, 5'd10, 5'd10, 1'b1, 8'd0, 8'd0, 24'h0));
		send_cmd(make_cmd(MODE_QUERY, 5'd10, 5'd10, 5'd10, 1'b0, 8'd255, 8'd0, 24'h0));
		// Open the x- side again so exactly one face shows.
		send_cmd(make_cmd(MODE_OCC, 5'd9, 5'd10, 5'd10, 1'b0, 8'd0, 8'd0, 24'h0));
		send_cmd(make_cmd(MODE_QUERY, 5'd10, 5'd10, 5'd10, 1'b0, 8'd128, 8'd0, 24'h0));
		// Top corner with its only in-grid y neighbor filled.
		send_cmd(make_cmd(MODE_OCC, 5'd31, 5'd30, 5'd31, 1'b1, 8'd0, 8'd0, 24'h0));
		send_cmd(make_cmd(MODE_QUERY, 5'd31, 5'd31, 5'd31, 1'b0, 8'd0, 8'd0, 24'h0));
	endtask

	// Mostly writes and queries packed into a small cluster, with some noise.
	task automatic test_random_traffic(input int n_items);
		voxel_cmd_t c;
		int sent;
		int pick;
		sent = 0;
		while (sent < n_items) begin
			if (sent % 30 == 0) begin
				move_cluster();
			end
			c = make_cmd(2'($urandom), 5'($urandom), 5'($urandom), 5'($urandom),
				1'($urandom), 8'($urandom), 8'($urandom), 24'($urandom));
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				c.mode = MODE_OCC;
				c.x = near_base(base_x);
				c.y = near_base(base_y);
				c.z = near_base(base_z);
				c.occ = ($urandom_range(0, 3) != 0);
			end else if (pick < 55) begin
				c.mode = MODE_PAL;
			end else if (pick < 93) begin
				c.mode = MODE_QUERY;
				c.x = near_base(base_x);
				c.y = near_base(base_y);
				c.z = near_base(base_z);
				c.cidx = known_color_index();
			end else if (pick < 97) begin
				c.mode = MODE_QUERY;
				c.cidx = known_color_index();
			end else begin
				c.mode = MODE_UNUSED;
			end
			send_cmd(c);
			if (c.mode != MODE_UNUSED) begin
				sent++;
			end
		end
	endtask

	// Receiver holds off for a long stretch while commands keep arriving back to back, every fourth an occupancy write.
	task automatic test_output_backpressure();
		voxel_cmd_t c;
		int k;
		gaps_on = 1'b0;
		hold_request = 1'b1;
		move_cluster();
		for (k = 0; k < PRESSURE_ITEMS; k++) begin
			c = make_cmd(MODE_QUERY, near_base(base_x), near_base(base_y),
				near_base(base_z), 1'($urandom), known_color_index(), 8'($urandom),
				24'($urandom));
			if (k % 4 == 3) begin
				c.mode = MODE_OCC;
			end
			send_cmd(c);
		end
		gaps_on = 1'b1;
	endtask

	// Face-side ready: a rotating stall pattern, overridden by a long hold on request.
	initial begin
		int phase;
		int hold_left;
		logic [15:0] stall_mask;
		phase = 0;
		hold_left = 0;
		stall_mask = 16'hFFFF;
		face_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				face_bus.ready <= 1'b0;
				hold_left--;
			end else begin
				if (phase == 0) begin
					case ($urandom_range(0, 2))
						0: stall_mask = 16'hFFFF;
						1: stall_mask = 16'($urandom) | 16'h0001;
						default: stall_mask = ~(16'h0001 << $urandom_range(0, 15));
					endcase
				end
				face_bus.ready <= stall_mask[phase];
				phase = (phase + 1) % 16;
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: face record field %s mismatch: expected %0d, actual %0d",
				$time, name, want, got);
			error_count++;
		end
	endfunction

	// Compares each face transaction with the oldest predicted record.
	always @(posedge clk) begin
		face_rec_t want;
		if (arst_n && face_bus.valid && face_bus.ready) begin
			if (pending_faces.size() == 0) begin
				$display("%0t: unexpected face record: expected none, actual face %0d at %0d,%0d,%0d",
					$time, face_bus.face_code, face_bus.place_x, face_bus.place_y,
					face_bus.place_z);
				error_count++;
			end else begin
				want = pending_faces.pop_front();
				check_field("face_code", want.face, face_bus.face_code);
				check_field("vertex_base", want.vbase, face_bus.vertex_base);
				check_field("red", want.red, face_bus.red);
				check_field("green", want.green, face_bus.green);
				check_field("blue", want.blue, face_bus.blue);
				check_field("place_x", want.px, face_bus.place_x);
				check_field("place_y", want.py, face_bus.place_y);
				check_field("place_z", want.pz, face_bus.place_z);
				check_field("last", want.is_last, face_bus.last);
				n_records++;
			end
		end
	end

	// Reset, the test sequence, drain and verdict.
	initial begin
		int guard;
		arst_n = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.mode = MODE_OCC;
		cmd_bus.pos_x = '0;
		cmd_bus.pos_y = '0;
		cmd_bus.pos_z = '0;
		cmd_bus.occupied = 1'b0;
		cmd_bus.color_index = '0;
		cmd_bus.palette_slot = '0;
		cmd_bus.palette_rgb = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_random_traffic(RANDOM_ITEMS);
		test_output_backpressure();

		@(negedge clk);
		cmd_bus.valid <= 1'b0;

		// Let the remaining records drain, then allow for a late extra one.
		guard = 0;
		while (pending_faces.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
		if (pending_faces.size() != 0) begin
			$display("%0t: %0d face records expected but never seen", $time,
				pending_faces.size());
			error_count += pending_faces.size();
		end

		$display("Run covered %0d occupancy writes, %0d palette writes, %0d queries, %0d records.",
			n_occ_writes, n_pal_writes, n_queries, n_records);
		$display("Included grid corners, a walled-in voxel, index wrap and a %0d-cycle output hold.",
			HOLD_CYCLES);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/vefe_pkg.sv
design/vefe_cmd_if.sv
design/vefe_face_if.sv
design/vefe_occ_grid.sv
design/vefe_palette.sv
design/vefe_seq.sv
design/voxel_exposed_face_emitter.sv
tb/testbench.sv
